>>> sv/assert_macros.svh
// Assertion macros used by the heart beat rate meter RTL.
// Included by the top level, which carries concurrent checks; has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_COMB(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("combinational check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define ASSERT_COMB(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/hrm_pkg.sv
// Package of the heart beat rate meter: command codes, decoded operations,
// queue status and back-end state types. No dependencies.
`default_nettype none
package hrm_pkg;

	localparam int CMD_BITS  = 2;
	localparam int TICK_BITS = 16;
	localparam int BPM_BITS  = 8;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_STOP   = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_SECOND = 2'd1;

	localparam logic [TICK_BITS-1:0] TICKS_RESET = 16'd1000;
	localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = 16'd512;

	typedef enum logic [2:0] {
		OP_ABOVE,
		OP_BELOW,
		OP_LEVEL,
		OP_TICK,
		OP_START,
		OP_STOP
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_RUN,
		BK_DIV
	} back_state_t;

endpackage
`default_nettype wire

>>> sv/hrm_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on hrm_pkg for the status struct.
`default_nettype none
module hrm_queue #(
	parameter int WIDTH = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output hrm_pkg::q_stat_t      stat
);
	import hrm_pkg::*;

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign dout       = entry_q[rd_ptr_q];
	assign stat.full  = count_q[1];
	assign stat.empty = (count_q == 2'd0);

endmodule
`default_nettype wire

>>> sv/hrm_front.sv
// Front end: accepts input requests and classifies them into operations,
// comparing samples against the threshold. Depends on hrm_pkg.
`default_nettype none
module hrm_front #(
	parameter int SAMPLE_BITS = 10,
	parameter int IN_W        = 16
) (
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [IN_W-1:0]          s_axis_tdata,
	input  wire logic [hrm_pkg::CMD_BITS-1:0] s_axis_tuser,
	input  wire logic [SAMPLE_BITS-1:0]   threshold,
	input  wire hrm_pkg::q_stat_t         q_stat,
	output logic                          q_push,
	output hrm_pkg::op_t                  q_op
);
	import hrm_pkg::*;

	logic [SAMPLE_BITS-1:0] sample;

	assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
	assign s_axis_tready = !q_stat.full;
	assign q_push        = s_axis_tvalid && !q_stat.full;

	always_comb begin
		case (s_axis_tuser)
			CMD_SAMPLE: begin
				if (sample > threshold) begin
					q_op = OP_ABOVE;
				end else if (sample < threshold) begin
					q_op = OP_BELOW;
				end else begin
					q_op = OP_LEVEL;
				end
			end
			CMD_TICK:  q_op = OP_TICK;
			CMD_START: q_op = OP_START;
			CMD_STOP:  q_op = OP_STOP;
			default:   q_op = OP_LEVEL;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/hrm_back.sv
// Back end: carries out queued operations on the recording counters, runs
// the bit-serial rate division on stop and holds the output register.
// Depends on hrm_pkg.
`default_nettype none
module hrm_back #(
	parameter int COUNT_BITS = 16,
	parameter int OUT_W      = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [hrm_pkg::TICK_BITS-1:0] ticks_per_second,
	input  wire hrm_pkg::q_stat_t              q_stat,
	input  wire hrm_pkg::op_t                  q_op,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [OUT_W-1:0]                   m_axis_tdata,
	output logic                               m_axis_tuser
);
	import hrm_pkg::*;

	localparam int DIV_BITS = COUNT_BITS + 6;
	localparam int CNT_W    = $clog2(DIV_BITS);

	back_state_t state_q, state_d;

	logic                  rec_q, rec_d;
	logic                  latched_q, latched_d;
	logic [COUNT_BITS-1:0] beat_q, beat_d;
	logic [TICK_BITS-1:0]  tick_q, tick_d;
	logic [COUNT_BITS-1:0] sec_q, sec_d;

	logic [COUNT_BITS-1:0] rem_q, rem_d;
	logic [DIV_BITS-1:0]   quo_q, quo_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;

	logic                  out_valid_q, out_valid_d;
	logic                  out_rec_q, out_rec_d;
	logic [COUNT_BITS-1:0] out_beat_q, out_beat_d;
	logic [COUNT_BITS-1:0] out_sec_q, out_sec_d;
	logic [BPM_BITS-1:0]   out_bpm_q, out_bpm_d;
	logic                  out_rep_q, out_rep_d;
	logic                  load_out;

	logic [TICK_BITS-1:0]  limit;
	logic [TICK_BITS-1:0]  tick_inc;
	logic [COUNT_BITS:0]   rem_sh;
	logic                  rem_ge;
	logic [DIV_BITS-1:0]   dividend;

	assign limit    = (ticks_per_second == '0) ? TICK_BITS'(1) : ticks_per_second;
	assign tick_inc = tick_q + TICK_BITS'(1);
	assign dividend = DIV_BITS'({beat_q, 6'b0}) - DIV_BITS'({beat_q, 2'b0});
	assign rem_sh   = {rem_q, quo_q[DIV_BITS-1]};
	assign rem_ge   = (rem_sh >= {1'b0, sec_q});

	always_comb begin
		state_d     = state_q;
		rec_d       = rec_q;
		latched_d   = latched_q;
		beat_d      = beat_q;
		tick_d      = tick_q;
		sec_d       = sec_q;
		rem_d       = rem_q;
		quo_d       = quo_q;
		cnt_d       = cnt_q;
		q_pop       = 1'b0;
		load_out    = 1'b0;
		out_bpm_d   = '0;
		out_rep_d   = 1'b0;
		case (state_q)
			BK_RUN: begin
				q_pop = !q_stat.empty && (!out_valid_q || m_axis_tready);
				if (q_pop) begin
					load_out = 1'b1;
					case (q_op)
						OP_ABOVE: begin
							if (rec_q && !latched_q) begin
								beat_d    = (beat_q == '1) ? beat_q : beat_q + COUNT_BITS'(1);
								latched_d = 1'b1;
							end
						end
						OP_BELOW: begin
							if (rec_q) begin
								latched_d = 1'b0;
							end
						end
						OP_TICK: begin
							if (rec_q) begin
								if (tick_inc >= limit) begin
									tick_d = '0;
									sec_d  = (sec_q == '1) ? sec_q : sec_q + COUNT_BITS'(1);
								end else begin
									tick_d = tick_inc;
								end
							end
						end
						OP_START: begin
							if (!rec_q) begin
								rec_d     = 1'b1;
								latched_d = 1'b0;
								beat_d    = '0;
								tick_d    = '0;
								sec_d     = '0;
							end
						end
						OP_STOP: begin
							if (rec_q) begin
								rec_d     = 1'b0;
								out_rep_d = 1'b1;
								if (sec_q != '0) begin
									load_out = 1'b0;
									state_d  = BK_DIV;
									rem_d    = '0;
									quo_d    = dividend;
									cnt_d    = CNT_W'(DIV_BITS - 1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_DIV: begin
				rem_d = rem_ge ? COUNT_BITS'(rem_sh - {1'b0, sec_q}) : COUNT_BITS'(rem_sh);
				quo_d = {quo_q[DIV_BITS-2:0], rem_ge};
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d   = BK_RUN;
					load_out  = 1'b1;
					out_rep_d = 1'b1;
					out_bpm_d = (|quo_d[DIV_BITS-1:BPM_BITS]) ? '1 : quo_d[BPM_BITS-1:0];
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
		out_rec_d  = rec_d;
		out_beat_d = beat_d;
		out_sec_d  = sec_d;
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (m_axis_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q       <= 1'b0;
			latched_q   <= 1'b0;
			beat_q      <= '0;
			tick_q      <= '0;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rec_q       <= rec_d;
			latched_q   <= latched_d;
			beat_q      <= beat_d;
			tick_q      <= tick_d;
			sec_q       <= sec_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		quo_q <= quo_d;
		cnt_q <= cnt_d;
		if (load_out) begin
			out_rec_q  <= out_rec_d;
			out_beat_q <= out_beat_d;
			out_sec_q  <= out_sec_d;
			out_bpm_q  <= out_bpm_d;
			out_rep_q  <= out_rep_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_bpm_q, out_sec_q, out_beat_q, out_rec_q});
	assign m_axis_tuser  = out_rep_q;

endmodule
`default_nettype wire

>>> sv/heart_beat_rate_meter.sv
// Top level of the heart beat rate meter: configuration registers, front
// end, request queue and back end. Depends on hrm_pkg, hrm_front, hrm_queue,
// hrm_back and assert_macros.svh.
//
// Requests enter on the s_axis channel: tuser carries the command (sample,
// tick, start, stop) and tdata the converter sample. Every request gives
// exactly one result on the m_axis channel, in order; tuser marks a result
// that closed a recording and carries a final rate. Registers are written
// through the cfg channel, which is always ready; the user must write them
// only while idle, as the block does not enforce it. Requests pass through
// the queue and the output register. Samples, ticks, starts and stops on an
// idle meter are taken one per cycle unless the receiver stalls. A stop that
// ends a recording with at least one whole second runs the bit-serial rate
// division, one quotient bit a cycle; requests behind it wait in the
// two-entry queue. A stalled receiver holds the output register, the queue
// fills and s_axis_tready falls. Reset clears the recording state and the
// counters and loads the threshold and ticks per second defaults.
`default_nettype none
`include "assert_macros.svh"
module heart_beat_rate_meter #(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// sample
	input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,
	// command
	input  wire logic [hrm_pkg::CMD_BITS-1:0]            s_axis_tuser,
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// recording, beat_total, elapsed_seconds, beats_per_minute
	output logic [((2 * COUNT_BITS + 9 + 7) / 8) * 8-1:0] m_axis_tdata,
	// report_valid
	output logic                                         m_axis_tuser,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [hrm_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [hrm_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
	import hrm_pkg::*;

	localparam int IN_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((2 * COUNT_BITS + 9 + 7) / 8) * 8;
	localparam int BEAT_LSB = 1;
	localparam int SEC_LSB  = 1 + COUNT_BITS;
	localparam int BPM_LSB  = 1 + 2 * COUNT_BITS;

	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [TICK_BITS-1:0]   ticks_q;
	q_stat_t                q_stat;
	logic                   q_push;
	logic                   q_pop;
	op_t                    push_op;
	logic [$bits(op_t)-1:0] pop_bits;
	logic                   res_take;
	logic                   res_rec;
	logic [COUNT_BITS-1:0]  res_beat;
	logic [COUNT_BITS-1:0]  res_sec;
	logic [BPM_BITS-1:0]    res_bpm;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET[SAMPLE_BITS-1:0];
			ticks_q     <= TICKS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PEAK_THRESHOLD:   threshold_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_TICKS_PER_SECOND: ticks_q     <= cfg_data[TICK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	hrm_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.IN_W       (IN_W)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.threshold    (threshold_q),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_op         (push_op)
	);

	hrm_queue #(
		.WIDTH($bits(op_t))
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (push_op),
		.pop   (q_pop),
		.dout  (pop_bits),
		.stat  (q_stat)
	);

	hrm_back #(
		.COUNT_BITS(COUNT_BITS),
		.OUT_W     (OUT_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ticks_per_second(ticks_q),
		.q_stat          (q_stat),
		.q_op            (op_t'(pop_bits)),
		.q_pop           (q_pop),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser)
	);

	assign res_take = m_axis_tvalid && m_axis_tready;
	assign res_rec  = m_axis_tdata[0];
	assign res_beat = m_axis_tdata[BEAT_LSB +: COUNT_BITS];
	assign res_sec  = m_axis_tdata[SEC_LSB +: COUNT_BITS];
	assign res_bpm  = m_axis_tdata[BPM_LSB +: BPM_BITS];

	`ASSERT_COMB(a_report_ends_rec, clk, arst_n, !(m_axis_tvalid && m_axis_tuser) || !res_rec)
	`ASSERT_COMB(a_bpm_only_on_report, clk, arst_n, !m_axis_tvalid || m_axis_tuser || (res_bpm == '0))
	`ASSERT_COMB(a_bpm_needs_second, clk, arst_n, !m_axis_tvalid || (res_sec != '0) || (res_bpm == '0))
	`ASSERT_COMB(a_no_beats_no_rate, clk, arst_n, !m_axis_tvalid || (res_beat != '0) || (res_bpm == '0))
	`ASSERT_NEXT(a_no_double_report, clk, arst_n, res_take && m_axis_tuser, !m_axis_tvalid || !m_axis_tuser)

endmodule
`default_nettype wire

>>> tb/sv/heart_beat_rate_meter_tb.sv
// Self-checking testbench of heart_beat_rate_meter: streams random and directed commands,
// predicts every result in a scoreboard and checks the output stream field by field.
// Depends on hrm_pkg and the heart_beat_rate_meter RTL only.
`timescale 1ns / 100ps
module heart_beat_rate_meter_tb;
	import hrm_pkg::*;

	localparam int OUT_W = 48;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 230;

	typedef struct packed {
		logic        recording;
		logic [15:0] beat_total;
		logic [15:0] elapsed_seconds;
		logic [7:0]  beats_per_minute;
		logic        report_valid;
	} reading_t;

	class meter_scoreboard;
		logic [9:0]  threshold;
		logic [15:0] ticks_per_sec;
		logic        recording;
		logic        latched;
		logic [15:0] beats;
		logic [15:0] tick_count;
		logic [15:0] seconds;
		reading_t    pending_readings[$];
		int unsigned failures;
		int unsigned checked;
		int unsigned reports;

		function new();
			threshold = 10'd512;
			ticks_per_sec = 16'd1000;
			recording = 1'b0;
			latched = 1'b0;
			beats = '0;
			tick_count = '0;
			seconds = '0;
			failures = 0;
			checked = 0;
			reports = 0;
		endfunction

		function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] value);
			if (idx == REG_PEAK_THRESHOLD) begin
				threshold = value[9:0];
			end else if (idx == REG_TICKS_PER_SECOND) begin
				ticks_per_sec = value;
			end
		endfunction

		function logic [7:0] rate_bpm();
			logic [31:0] quotient;
			if (seconds == 0) begin
				return 8'd0;
			end
			quotient = ({16'd0, beats} * 32'd60) / {16'd0, seconds};
			return (quotient > 32'd255) ? 8'd255 : quotient[7:0];
		endfunction

		// Advances the predicted meter state by one accepted request and queues its reading.
		function void take_request(logic [CMD_BITS-1:0] cmd, logic [9:0] smp);
			reading_t    r;
			logic [15:0] limit;
			r.beats_per_minute = 8'd0;
			r.report_valid = 1'b0;
			case (cmd)
				CMD_SAMPLE: begin
					if (recording) begin
						if (smp > threshold && !latched) begin
							if (beats != 16'hFFFF) beats = beats + 16'd1;
							latched = 1'b1;
						end
						if (smp < threshold) latched = 1'b0;
					end
				end
				CMD_TICK: begin
					if (recording) begin
						limit = (ticks_per_sec == 0) ? 16'd1 : ticks_per_sec;
						tick_count = tick_count + 16'd1;
						if (tick_count >= limit) begin
							tick_count = '0;
							if (seconds != 16'hFFFF) seconds = seconds + 16'd1;
						end
					end
				end
				CMD_START: begin
					if (!recording) begin
						recording = 1'b1;
						latched = 1'b0;
						beats = '0;
						tick_count = '0;
						seconds = '0;
					end
				end
				default: begin
					if (recording) begin
						recording = 1'b0;
						r.beats_per_minute = rate_bpm();
						r.report_valid = 1'b1;
					end
				end
			endcase
			r.recording = recording;
			r.beat_total = beats;
			r.elapsed_seconds = seconds;
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_reading(logic [OUT_W-1:0] data, logic report);
			reading_t want;
			if (pending_readings.size() == 0) begin
				$error("result arrived with no request outstanding");
				failures++;
				return;
			end
			want = pending_readings.pop_front();
			checked++;
			if (want.report_valid) reports++;
			compare_field("recording", 32'(want.recording), 32'(data[0]));
			compare_field("beat_total", 32'(want.beat_total), 32'(data[16:1]));
			compare_field("elapsed_seconds", 32'(want.elapsed_seconds), 32'(data[32:17]));
			compare_field("beats_per_minute", 32'(want.beats_per_minute), 32'(data[40:33]));
			compare_field("report_valid", 32'(want.report_valid), 32'(report));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [15:0]             s_axis_tdata = '0;
	logic [CMD_BITS-1:0]     s_axis_tuser = CMD_SAMPLE;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_W-1:0]        m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_PEAK_THRESHOLD;
	logic [15:0]             cfg_data = '0;

	meter_scoreboard sb = new();
	int unsigned     send_idle_pct = 37;
	int unsigned     recv_idle_pct = 48;
	int unsigned     hold_request = 0;
	int unsigned     hold_left = 0;
	int unsigned     cycle_count = 0;

	heart_beat_rate_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("heart_beat_rate_meter_tb: FAIL");
			$finish;
		end
	end

	// Result side: checks each accepted result and throttles tready, including long holds.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_reading(m_axis_tdata, m_axis_tuser);
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Leaves tvalid high after acceptance so that back-to-back requests follow each other with no idle gap.
	task automatic offer_request(input logic [CMD_BITS-1:0] cmd, input logic [9:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, smp};
		do @(posedge clk); while (!s_axis_tready);
		sb.take_request(cmd, smp);
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, value);
	endtask

	task automatic configure(input logic [15:0] thr, input logic [15:0] tps);
		write_register(REG_PEAK_THRESHOLD, thr);
		write_register(REG_TICKS_PER_SECOND, tps);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Samples are drawn anywhere in range, right around the threshold or at the two extremes.
	function automatic logic [9:0] pick_sample();
		int v;
		case ($urandom_range(3))
			0, 1: v = $urandom_range(1023);
			2: v = int'(sb.threshold) + int'($urandom_range(2)) - 1;
			default: v = $urandom_range(1) ? 1023 : 0;
		endcase
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return v[9:0];
	endfunction

	initial begin
		int made;
		int len;
		int tick_pct;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A short recording with the reset threshold.
		offer_request(CMD_START, 10'd0);
		offer_request(CMD_SAMPLE, 10'd513);
		offer_request(CMD_STOP, 10'd0);
		drain_results();

		for (int phase = 0; phase < 5; phase++) begin
			if (phase < 2) begin
				send_idle_pct = 37;
				recv_idle_pct = 48;
			end else if (phase < 4) begin
				send_idle_pct = 48;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				0: configure(16'd512, 16'd2);
				1: configure(16'd1023, 16'd65535);
				2: configure(16'd0, 16'd1);
				3: configure(16'($urandom_range(1022, 1)), 16'($urandom_range(6, 1)));
				default: configure(16'($urandom_range(1023)), 16'd3);
			endcase

			if (phase == 0) begin
				offer_request(CMD_STOP, 10'd0);
				offer_request(CMD_SAMPLE, 10'd1023);
				offer_request(CMD_TICK, 10'd0);
				offer_request(CMD_START, 10'd0);
				offer_request(CMD_START, 10'd1023);
				offer_request(CMD_SAMPLE, 10'd1023);
				offer_request(CMD_SAMPLE, 10'd1023);
				offer_request(CMD_SAMPLE, 10'd512);
				offer_request(CMD_SAMPLE, 10'd0);
				offer_request(CMD_SAMPLE, 10'd512);
				offer_request(CMD_SAMPLE, 10'd513);
				offer_request(CMD_SAMPLE, 10'd511);
				offer_request(CMD_TICK, 10'd0);
				offer_request(CMD_TICK, 10'd0);
				offer_request(CMD_TICK, 10'd0);
				offer_request(CMD_STOP, 10'd0);
				offer_request(CMD_START, 10'd0);
				offer_request(CMD_SAMPLE, 10'd1023);
				offer_request(CMD_STOP, 10'd0);
			end
			if (phase == 0 || phase == 3) begin
				hold_request = 90;
			end

			made = 0;
			while (made < PHASE_ITEMS) begin
				if ($urandom_range(9) == 0) begin
					offer_request(CMD_BITS'($urandom_range(3)), 10'($urandom_range(1023)));
					made += 1;
				end else begin
					tick_pct = $urandom_range(60, 3);
					len = $urandom_range(40, 1);
					offer_request(CMD_START, 10'($urandom_range(1023)));
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(99) < tick_pct) begin
							offer_request(CMD_TICK, 10'($urandom_range(1023)));
						end else if ($urandom_range(29) == 0) begin
							offer_request(CMD_START, 10'($urandom_range(1023)));
						end else begin
							offer_request(CMD_SAMPLE, pick_sample());
						end
					end
					offer_request(CMD_STOP, 10'($urandom_range(1023)));
					made += len + 2;
				end
			end
			drain_results();
		end

		// A zero tick count per second makes every tick a whole second.
		configure(16'd512, 16'd0);
		offer_request(CMD_START, 10'd0);
		repeat (6) begin
			offer_request(CMD_TICK, 10'd0);
			offer_request(CMD_SAMPLE, 10'd1023);
			offer_request(CMD_SAMPLE, 10'd0);
		end
		offer_request(CMD_STOP, 10'd0);
		drain_results();

		$display("Checked %0d results, %0d of them closing a recording with a rate report,",
			sb.checked, sb.reports);
		$display("over six register settings, random stalls on both sides and a long output hold.");
		if (sb.failures == 0) begin
			$display("heart_beat_rate_meter_tb: PASS");
		end else begin
			$display("heart_beat_rate_meter_tb: FAIL");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+sv
sv/hrm_pkg.sv
sv/hrm_queue.sv
sv/hrm_front.sv
sv/hrm_back.sv
sv/heart_beat_rate_meter.sv
tb/sv/heart_beat_rate_meter_tb.sv
